FILE: hw/rtl/hps_pkg.sv
// Package for the HRRN process scheduler: field widths, the slot record,
// and the command/status structs between controller and datapath.
// No dependencies.
package hps_pkg;

  localparam int ID_W      = 8;
  localparam int TIME_W    = 32;
  localparam int LEFT_W    = 16;
  localparam int PROD_W    = TIME_W + LEFT_W;
  localparam int CNT_OUT_W = 5;

  // One waiting-table entry as stored in the slot memory.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start;
    logic [LEFT_W-1:0] left;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Operation codes of the input channel.
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_ARRIVE = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic exec_arrive;
    logic exec_tick;
    logic scan_start;
    logic mul;
    logic cmp;
    logic sh_start;
    logic sh_step;
    logic load;
    logic out_load;
  } hps_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_arrival;
    logic need_pick;
    logic table_empty;
    logic scan_more;
    logic sh_any;
    logic sh_more;
  } hps_sts_t;

endpackage

FILE: hw/rtl/hps_if.sv
// Channel interfaces of the HRRN scheduler: the item input channel and
// the result output channel. Field widths come from hps_pkg.
interface hps_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [hps_pkg::ID_W-1:0]   proc_id;
  logic [hps_pkg::TIME_W-1:0] arrival_time;
  logic [hps_pkg::LEFT_W-1:0] burst_time;

  modport source(output valid, operation, proc_id, arrival_time, burst_time,
                 input ready);
  modport sink(input valid, operation, proc_id, arrival_time, burst_time,
               output ready);
endinterface

interface hps_out_if;
  logic                          valid;
  logic                          ready;
  logic                          running_valid;
  logic [hps_pkg::ID_W-1:0]      running_id;
  logic [hps_pkg::LEFT_W-1:0]    running_left;
  logic [hps_pkg::CNT_OUT_W-1:0] waiting_count;
  logic                          arrival_dropped;

  modport source(output valid, running_valid, running_id, running_left,
                 waiting_count, arrival_dropped, input ready);
  modport sink(input valid, running_valid, running_id, running_left,
               waiting_count, arrival_dropped, output ready);
endinterface

FILE: hw/rtl/hrrn_process_scheduler_core.sv
// Top level of the non-preemptive HRRN process scheduler.
// Depends on hps_pkg, hps_if, hps_ram, hps_ctrl and hps_dp.
//
//  Channel   Direction  Handshake      Payload
//  in_chan   input      valid / ready  operation, proc_id, arrival_time, burst_time
//  out_chan  output     valid / ready  running_valid, running_id, running_left,
//                                      waiting_count, arrival_dropped
//
// An arrival transaction or a tick that needs no new pick passes from
// acceptance through the execute and finish states. A tick that picks from
// the waiting entries visits a multiply state and a compare state for each
// entry, then the removal shift and the load; the single read port of the
// slot memory and the multiply-then-compare per entry set that pace.
// Reset is synchronous and active low; it empties the table and clears the
// time counter and the running process at once, with no clearing pass.
// The result sits in an output register, so the next transaction is taken
// while a result waits; a stalled output only holds the block at the end
// of the following item.
module hrrn_process_scheduler_core #(
  parameter int PROC_SLOTS = 16
) (
  input logic      clk,
  input logic      rst_n,
  hps_in_if.sink   in_chan,
  hps_out_if.source out_chan
);

  // Commands and status between the sequencer and the datapath.
  hps_pkg::hps_cmd_t cmd;
  hps_pkg::hps_sts_t sts;

  logic in_ready;
  logic out_valid;

  // The controller owns the handshakes and steps through the scan and
  // the shift that closes the gap left by the chosen process.
  hps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath keeps the table in a memory in arrival order with no
  // gaps, so a fill count stands in for per-slot valid bits.
  hps_dp #(
    .PROC_SLOTS(PROC_SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_chan.operation),
    .in_proc_id         (in_chan.proc_id),
    .in_arrival_time    (in_chan.arrival_time),
    .in_burst_time      (in_chan.burst_time),
    .out_running_valid  (out_chan.running_valid),
    .out_running_id     (out_chan.running_id),
    .out_running_left   (out_chan.running_left),
    .out_waiting_count  (out_chan.waiting_count),
    .out_arrival_dropped(out_chan.arrival_dropped)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

endmodule

FILE: hw/rtl/hps_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module hps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/hps_ctrl.sv
// Controller of the HRRN scheduler: sequences arrival, tick, scan, shift
// and result hand-off. Depends on hps_pkg for the command/status structs.
module hps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  hps_pkg::hps_sts_t sts,
  output hps_pkg::hps_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_CMP,
    S_SH0,
    S_SH1,
    S_LOAD,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_arrival) begin
          cmd.exec_arrive = 1'b1;
          state_nxt       = S_FINISH;
        end else begin
          cmd.exec_tick = 1'b1;
          if (sts.need_pick && !sts.table_empty) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_MUL;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = sts.scan_more ? S_MUL : S_SH0;
      end
      S_SH0: begin
        cmd.sh_start = 1'b1;
        state_nxt    = sts.sh_any ? S_SH1 : S_LOAD;
      end
      S_SH1: begin
        cmd.sh_step = 1'b1;
        state_nxt   = sts.sh_more ? S_SH1 : S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A new result only appears when an item has just been finished.
  a_rose_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result raised outside of finish");

  // The running process is only loaded after the removal shift.
  a_load_after_shift: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> ($past(state_r == S_SH0) || $past(state_r == S_SH1)))
    else $error("load without removal shift");

endmodule

FILE: hw/rtl/hps_dp.sv
// Datapath of the HRRN scheduler: slot memory, time counter, running
// process, ratio compare and result register. Depends on hps_pkg, hps_ram.
module hps_dp #(
  parameter int PROC_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hps_pkg::hps_cmd_t             cmd,
  output hps_pkg::hps_sts_t             sts,
  input  logic                          in_operation,
  input  logic [hps_pkg::ID_W-1:0]      in_proc_id,
  input  logic [hps_pkg::TIME_W-1:0]    in_arrival_time,
  input  logic [hps_pkg::LEFT_W-1:0]    in_burst_time,
  output logic                          out_running_valid,
  output logic [hps_pkg::ID_W-1:0]      out_running_id,
  output logic [hps_pkg::LEFT_W-1:0]    out_running_left,
  output logic [hps_pkg::CNT_OUT_W-1:0] out_waiting_count,
  output logic                          out_arrival_dropped
);

  localparam int AW = $clog2(PROC_SLOTS);
  localparam int CW = $clog2(PROC_SLOTS + 1);

  // Latched input item.
  logic                       op_r;
  logic [hps_pkg::ID_W-1:0]   in_id_r;
  logic [hps_pkg::TIME_W-1:0] in_start_r;
  logic [hps_pkg::LEFT_W-1:0] in_burst_r;

  // Architectural state.
  logic [hps_pkg::TIME_W-1:0] tick_r;
  logic [CW-1:0]              count_r;
  logic                       run_valid_r;
  logic [hps_pkg::ID_W-1:0]   run_id_r;
  logic [hps_pkg::LEFT_W-1:0] run_left_r;
  logic                       dropped_r;

  // Scan and shift working registers.
  logic [AW-1:0]              scan_idx_r;
  logic [AW-1:0]              cand_idx_r;
  logic [AW-1:0]              best_idx_r;
  logic [AW-1:0]              ptr_r;
  logic                       found_r;
  logic [hps_pkg::TIME_W-1:0] cand_w_r, best_w_r;
  logic [hps_pkg::LEFT_W-1:0] cand_l_r, best_l_r;
  logic [hps_pkg::ID_W-1:0]   cand_id_r, best_id_r;
  logic [hps_pkg::PROD_W-1:0] p_cand_r, p_best_r;

  // Result register.
  logic                          res_valid_r;
  logic [hps_pkg::ID_W-1:0]      res_id_r;
  logic [hps_pkg::LEFT_W-1:0]    res_left_r;
  logic [hps_pkg::CNT_OUT_W-1:0] res_count_r;
  logic                          res_dropped_r;

  logic                       full;
  logic                       need_pick;
  logic                       better;
  logic [hps_pkg::TIME_W-1:0] rd_wait;
  logic [hps_pkg::LEFT_W-1:0] burst_fix;
  hps_pkg::slot_t             rd_slot, wr_slot;
  logic [hps_pkg::SLOT_W-1:0] ram_rdata;
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;

  assign full      = (count_r == CW'(PROC_SLOTS));
  assign need_pick = !run_valid_r || (run_left_r == '0);
  assign rd_slot   = hps_pkg::slot_t'(ram_rdata);
  assign rd_wait   = tick_r - rd_slot.start;
  assign burst_fix = (in_burst_r == '0) ? hps_pkg::LEFT_W'(1) : in_burst_r;
  // Strict compare keeps the earliest entry on a tie.
  assign better    = !found_r || (p_cand_r > p_best_r);

  assign sts.is_arrival  = (op_r == hps_pkg::OP_ARRIVE);
  assign sts.need_pick   = need_pick;
  assign sts.table_empty = (count_r == '0);
  assign sts.scan_more   = (CW'(scan_idx_r) + CW'(1)) < count_r;
  assign sts.sh_any      = (CW'(best_idx_r) + CW'(1)) < count_r;
  assign sts.sh_more     = (CW'(ptr_r) + CW'(1)) < count_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    wr_slot   = '{id: in_id_r, start: in_start_r, left: burst_fix};
    if (cmd.exec_arrive && !full) begin
      ram_we = 1'b1;
    end else if (cmd.sh_step) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_r - AW'(1);
      wr_slot   = rd_slot;
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    priority if (cmd.scan_start) begin
      ram_re = 1'b1;
    end else if (cmd.cmp) begin
      ram_re    = sts.scan_more;
      ram_raddr = scan_idx_r + AW'(1);
    end else if (cmd.sh_start) begin
      ram_re    = sts.sh_any;
      ram_raddr = best_idx_r + AW'(1);
    end else if (cmd.sh_step) begin
      ram_re    = sts.sh_more;
      ram_raddr = ptr_r + AW'(1);
    end else begin
      ram_re = 1'b0;
    end
  end

  hps_ram #(
    .WIDTH(hps_pkg::SLOT_W),
    .DEPTH(PROC_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_slot),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // State that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      count_r     <= '0;
      run_valid_r <= 1'b0;
      run_id_r    <= '0;
      run_left_r  <= '0;
    end else begin
      if (cmd.exec_arrive && !full) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.exec_tick) begin
        tick_r <= tick_r + hps_pkg::TIME_W'(1);
        if (!cmd.scan_start) begin
          if (need_pick) begin
            run_valid_r <= 1'b0;
            run_id_r    <= '0;
            run_left_r  <= '0;
          end else begin
            run_left_r <= run_left_r - hps_pkg::LEFT_W'(1);
          end
        end
      end
      if (cmd.load) begin
        count_r     <= count_r - CW'(1);
        run_valid_r <= 1'b1;
        run_id_r    <= best_id_r;
        run_left_r  <= best_l_r - ((best_l_r != '0) ? hps_pkg::LEFT_W'(1) : '0);
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_operation;
      in_id_r    <= in_proc_id;
      in_start_r <= in_arrival_time;
      in_burst_r <= in_burst_time;
    end
    if (cmd.exec_arrive) begin
      dropped_r <= full;
    end
    if (cmd.exec_tick) begin
      dropped_r <= 1'b0;
    end
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
      found_r    <= 1'b0;
    end
    if (cmd.mul) begin
      cand_w_r   <= rd_wait;
      cand_l_r   <= rd_slot.left;
      cand_id_r  <= rd_slot.id;
      cand_idx_r <= scan_idx_r;
      p_cand_r   <= hps_pkg::PROD_W'(rd_wait) * hps_pkg::PROD_W'(best_l_r);
      p_best_r   <= hps_pkg::PROD_W'(best_w_r) * hps_pkg::PROD_W'(rd_slot.left);
    end
    if (cmd.cmp) begin
      if (better) begin
        found_r    <= 1'b1;
        best_w_r   <= cand_w_r;
        best_l_r   <= cand_l_r;
        best_id_r  <= cand_id_r;
        best_idx_r <= cand_idx_r;
      end
      if (sts.scan_more) begin
        scan_idx_r <= scan_idx_r + AW'(1);
      end
    end
    if (cmd.sh_start) begin
      ptr_r <= best_idx_r + AW'(1);
    end
    if (cmd.sh_step) begin
      ptr_r <= ptr_r + AW'(1);
    end
    if (cmd.out_load) begin
      res_valid_r   <= run_valid_r;
      res_id_r      <= run_valid_r ? run_id_r : '0;
      res_left_r    <= run_valid_r ? run_left_r : '0;
      res_count_r   <= hps_pkg::CNT_OUT_W'(count_r);
      res_dropped_r <= dropped_r;
    end
  end

  assign out_running_valid   = res_valid_r;
  assign out_running_id      = res_id_r;
  assign out_running_left    = res_left_r;
  assign out_waiting_count   = res_count_r;
  assign out_arrival_dropped = res_dropped_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(PROC_SLOTS))
    else $error("waiting count above table size");

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (count_r != '0))
    else $error("removal from an empty table");

  a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |-> (CW'(scan_idx_r) < count_r))
    else $error("scan index beyond the filled table");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for hrrn_process_scheduler_core: a shadow HRRN table,
// driven tick and arrival transactions, and a checker on every result.
// Depends on hps_pkg, hps_if and the scheduler RTL.
module testbench;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 850;
  localparam int SETTLE      = 80;   // longer than the slowest pick

  typedef struct packed {
    logic                       operation;
    logic [hps_pkg::ID_W-1:0]   proc_id;
    logic [hps_pkg::TIME_W-1:0] arrival_time;
    logic [hps_pkg::LEFT_W-1:0] burst_time;
  } sched_item_t;

  typedef struct packed {
    logic                          running_valid;
    logic [hps_pkg::ID_W-1:0]      running_id;
    logic [hps_pkg::LEFT_W-1:0]    running_left;
    logic [hps_pkg::CNT_OUT_W-1:0] waiting_count;
    logic                          arrival_dropped;
  } sched_status_t;

  // Shadow copy of the scheduler: it replays every accepted transaction and
  // queues the status the block must report for it.
  class hrrn_shadow;
    logic [hps_pkg::TIME_W-1:0] now_ticks;
    bit                         slot_used  [SLOTS];
    logic [hps_pkg::ID_W-1:0]   slot_pid   [SLOTS];
    logic [hps_pkg::TIME_W-1:0] slot_since [SLOTS];
    logic [hps_pkg::LEFT_W-1:0] slot_need  [SLOTS];
    bit                         cur_valid;
    logic [hps_pkg::ID_W-1:0]   cur_id;
    logic [hps_pkg::LEFT_W-1:0] cur_left;
    sched_status_t              due_status[$];
    int mismatches, checked, ticks_seen, arrivals_seen, drops_seen, picks_seen;

    function new();
      now_ticks = '0;
      foreach (slot_used[i]) begin
        slot_used[i]  = 1'b0;
        slot_pid[i]   = '0;
        slot_since[i] = '0;
        slot_need[i]  = '0;
      end
      cur_valid = 1'b0;
      cur_id    = '0;
      cur_left  = '0;
      mismatches = 0;
      checked = 0;
      ticks_seen = 0;
      arrivals_seen = 0;
      drops_seen = 0;
      picks_seen = 0;
    endfunction

    function int occupancy();
      int n;
      n = 0;
      foreach (slot_used[i]) if (slot_used[i]) n++;
      return n;
    endfunction

    function int outstanding();
      return due_status.size();
    endfunction

    // Highest response ratio wins; ratios are compared by cross-multiplying
    // wait by the other entry's remaining time, and a strict compare keeps
    // the earliest entry on a tie.
    function sched_status_t advance_schedule(sched_item_t it);
      sched_status_t              st;
      int                         n, best;
      bit                         found;
      logic [63:0]                bw, bl, w, l;
      logic [hps_pkg::TIME_W-1:0] waited;
      st = '0;
      if (it.operation == hps_pkg::OP_ARRIVE) begin
        arrivals_seen++;
        n = occupancy();
        if (n >= SLOTS) begin
          st.arrival_dropped = 1'b1;
          drops_seen++;
        end else begin
          slot_used[n]  = 1'b1;
          slot_pid[n]   = it.proc_id;
          slot_since[n] = it.arrival_time;
          // A zero burst is stored as a single tick.
          slot_need[n]  = (it.burst_time == '0) ? hps_pkg::LEFT_W'(1) : it.burst_time;
        end
      end else begin
        ticks_seen++;
        now_ticks = now_ticks + hps_pkg::TIME_W'(1);
        if (!cur_valid || cur_left == '0) begin
          found = 1'b0;
          best  = 0;
          bw    = '0;
          bl    = 64'd1;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i]) begin
              // The wait is taken modulo 2^32, so a start in the future
              // looks like a very long wait.
              waited = now_ticks - slot_since[i];
              w = 64'(waited);
              l = 64'(slot_need[i]);
              if (!found || w * bl > bw * l) begin
                found = 1'b1;
                best  = i;
                bw    = w;
                bl    = l;
              end
            end
          end
          if (found) begin
            picks_seen++;
            cur_valid = 1'b1;
            cur_id    = slot_pid[best];
            cur_left  = slot_need[best];
            for (int i = best; i + 1 < SLOTS; i++) begin
              slot_used[i]  = slot_used[i+1];
              slot_pid[i]   = slot_pid[i+1];
              slot_since[i] = slot_since[i+1];
              slot_need[i]  = slot_need[i+1];
            end
            slot_used[SLOTS-1]  = 1'b0;
            slot_pid[SLOTS-1]   = '0;
            slot_since[SLOTS-1] = '0;
            slot_need[SLOTS-1]  = '0;
          end else begin
            cur_valid = 1'b0;
            cur_id    = '0;
            cur_left  = '0;
          end
        end
        if (cur_valid && cur_left > '0) cur_left = cur_left - hps_pkg::LEFT_W'(1);
      end
      st.running_valid = cur_valid;
      st.running_id    = cur_valid ? cur_id : '0;
      st.running_left  = cur_valid ? cur_left : '0;
      st.waiting_count = hps_pkg::CNT_OUT_W'(occupancy());
      return st;
    endfunction

    function void accept_item(sched_item_t it);
      due_status.push_back(advance_schedule(it));
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("field %s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(sched_status_t got);
      sched_status_t want;
      if (due_status.size() == 0) begin
        $error("result with no transaction waiting for it: %p", got);
        mismatches++;
        return;
      end
      want = due_status.pop_front();
      checked++;
      compare_field("running_valid", want.running_valid, got.running_valid);
      compare_field("running_id", want.running_id, got.running_id);
      compare_field("running_left", want.running_left, got.running_left);
      compare_field("waiting_count", want.waiting_count, got.waiting_count);
      compare_field("arrival_dropped", want.arrival_dropped, got.arrival_dropped);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  hps_in_if  in_chan ();
  hps_out_if out_chan ();

  hrrn_process_scheduler_core #(
    .PROC_SLOTS(SLOTS)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  hrrn_shadow shadow = new();

  int          cycle_count = 0;
  int          holdoff_cycles = 0;   // set by the sender, consumed by the receiver
  int          send_gap_max = 6;
  logic [31:0] ticks_sent = '0;      // ticks offered so far, used to aim arrival times

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** hrrn_process_scheduler_core: FAILED **");
      $finish;
    end
  end

  // Offers one transaction after a random idle gap and returns once it has
  // been accepted. Valid stays high across back-to-back transactions.
  task automatic offer_item(input logic op, input logic [hps_pkg::ID_W-1:0] pid,
                            input logic [hps_pkg::TIME_W-1:0] start,
                            input logic [hps_pkg::LEFT_W-1:0] burst);
    int          gap;
    sched_item_t it;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.operation    <= op;
    in_chan.proc_id      <= pid;
    in_chan.arrival_time <= start;
    in_chan.burst_time   <= burst;
    do @(posedge clk); while (!in_chan.ready);
    it.operation    = op;
    it.proc_id      = pid;
    it.arrival_time = start;
    it.burst_time   = burst;
    shadow.accept_item(it);
    if (op == hps_pkg::OP_TICK) ticks_sent = ticks_sent + 1;
  endtask

  task automatic offer_tick();
    offer_item(hps_pkg::OP_TICK, hps_pkg::ID_W'($urandom_range(0, 255)), $urandom,
               hps_pkg::LEFT_W'($urandom_range(0, 65535)));
  endtask

  // The sender goes quiet so that no transaction is offered while it waits.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (shadow.outstanding() > 0) @(posedge clk);
  endtask

  // Directed opening: empty ticks, a zero burst that runs and finishes,
  // a full table with a future start and a tie, then a dropped arrival
  // carrying the extreme field values.
  task automatic run_directed();
    logic [hps_pkg::ID_W-1:0]   pid;
    logic [hps_pkg::TIME_W-1:0] start;
    logic [hps_pkg::LEFT_W-1:0] burst;
    offer_tick();
    offer_item(hps_pkg::OP_ARRIVE, 8'h00, 32'h0, 16'h0);
    offer_tick();
    offer_tick();
    for (int i = 0; i < SLOTS; i++) begin
      case (i)
        0: begin
          pid = 8'h01; start = 32'd0; burst = 16'd4;
        end
        1: begin
          // Same ratio as the entry before it; the earlier one must win.
          pid = 8'h02; start = 32'd0; burst = 16'd4;
        end
        2: begin
          pid = 8'h80; start = 32'd1; burst = 16'd2;
        end
        3: begin
          pid = 8'h7F; start = 32'd3; burst = 16'd1;
        end
        4: begin
          // A start numerically past the current tick wraps modulo 2^32, here into a small wait.
          pid = 8'hFE; start = 32'hFFFF_FFF0; burst = 16'd3;
        end
        default: begin
          pid = 8'(16 + i); start = 32'(i % 4); burst = 16'(1 + i % 5);
        end
      endcase
      offer_item(hps_pkg::OP_ARRIVE, pid, start, burst);
    end
    offer_item(hps_pkg::OP_ARRIVE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    repeat (4) offer_tick();
  endtask

  // Random traffic in blocks with their own arrival mix, so the table fills,
  // drops and drains again. Burst times stay short so that many picks happen;
  // long bursts come only near the end, where they cannot starve the run.
  task automatic run_random();
    int                         arrive_pct;
    int                         pick;
    logic [hps_pkg::TIME_W-1:0] start;
    logic [hps_pkg::LEFT_W-1:0] burst;
    arrive_pct = 50;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) begin
        arrive_pct   = $urandom_range(20, 70);
        send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
      end
      if (n == 300) drain_results();
      if (n == 500) begin
        holdoff_cycles = 300;
        send_gap_max   = 0;
      end
      if ($urandom_range(0, 99) < arrive_pct) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) start = $urandom;
        else if (pick < 10) start = ticks_sent + $urandom_range(1, 1000);
        else start = ticks_sent - $urandom_range(0, 30);
        pick = $urandom_range(0, 99);
        if (n > RAND_ITEMS - 40 && pick < 25) begin
          burst = hps_pkg::LEFT_W'($urandom_range(0, 65535));
        end else if (pick < 5) begin
          burst = 16'd0;
        end else if (pick < 20) begin
          burst = hps_pkg::LEFT_W'($urandom_range(1, 40));
        end else begin
          burst = hps_pkg::LEFT_W'($urandom_range(1, 6));
        end
        offer_item(hps_pkg::OP_ARRIVE, hps_pkg::ID_W'($urandom_range(0, 255)),
                   start, burst);
      end else begin
        offer_tick();
      end
    end
  endtask

  // Result side: a random stall before each transaction, sometimes whole
  // stretches with none, and one long hold-off when the sender asks for it.
  initial begin
    int   stall;
    int   stall_max;
    int   taken;
    sched_status_t got;
    out_chan.ready <= 1'b0;
    stall_max = 6;
    taken = 0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (taken % 50 == 0) stall_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
      stall = $urandom_range(0, stall_max);
      if (holdoff_cycles > 0) begin
        stall = holdoff_cycles;
        holdoff_cycles = 0;
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      got.running_valid   = out_chan.running_valid;
      got.running_id      = out_chan.running_id;
      got.running_left    = out_chan.running_left;
      got.waiting_count   = out_chan.waiting_count;
      got.arrival_dropped = out_chan.arrival_dropped;
      shadow.match_result(got);
      taken++;
    end
  end

  initial begin
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.operation    <= hps_pkg::OP_TICK;
    in_chan.proc_id      <= '0;
    in_chan.arrival_time <= '0;
    in_chan.burst_time   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random();

    // Everything is in; wait for the last results, then give the block
    // time to show any result it should not produce.
    @(posedge clk);
    in_chan.valid <= 1'b0;
    drain_results();
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d ticks and %0d arrivals (%0d dropped), %0d picks from the table.",
             shadow.ticks_seen, shadow.arrivals_seen, shadow.drops_seen, shadow.picks_seen);
    $display("Checked %0d results, %0d mismatches.", shadow.checked, shadow.mismatches);
    if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
      $display("** hrrn_process_scheduler_core: PASSED **");
    end else begin
      $display("** hrrn_process_scheduler_core: FAILED **");
    end
    $finish;
  end

endmodule
